>>> sv/srw_pkg.sv
// Package for the session replay window block.
// Holds default sizes, verdict codes, controller states and command/status bundles.
// No dependencies.
`default_nettype none

package srw_pkg;

  localparam int ENDPOINTS_DEF     = 3;
  localparam int RETIRED_DEPTH_DEF = 8;
  localparam int WINDOW_BITS_DEF   = 32;

  typedef enum logic [2:0] {
    V_OK      = 3'd0,
    V_BAD     = 3'd1,
    V_RETIRED = 3'd2,
    V_DUP     = 3'd3,
    V_OLD     = 3'd4,
    V_QUERY   = 3'd5
  } verdict_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_SCAN,
    ST_UPDATE,
    ST_RESP
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic     load;         // capture input transfer
    logic     scan_clr;     // reset retired-list scan
    logic     scan_run;     // step retired-list scan
    logic     set_verdict;  // store a fixed verdict
    verdict_t code;
    logic     update;       // commit window / retire, store computed verdict
  } srw_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic bad;
    logic query;
    logic same_session;
    logic hit;
    logic scan_done;
  } srw_stat_t;

endpackage

`default_nettype wire

>>> sv/srw_ctrl.sv
// Controller state machine for the session replay window block.
// Depends on srw_pkg; drives srw_dp through srw_cmd_t, reads srw_stat_t.
`default_nettype none

module srw_ctrl
  import srw_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  input  wire srw_stat_t stat,
  output srw_cmd_t       cmd,
  output logic           busy,
  output logic           out_strobe
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    cmd             = '0;
    cmd.code        = V_OK;
    busy            = 1'b1;
    out_strobe      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        cmd.scan_clr = 1'b1;
        if (stat.bad) begin
          cmd.set_verdict = 1'b1;
          cmd.code        = V_BAD;
          state_nxt       = ST_RESP;
        end else if (stat.query) begin
          cmd.set_verdict = 1'b1;
          cmd.code        = V_QUERY;
          state_nxt       = ST_RESP;
        end else if (stat.same_session) begin
          state_nxt = ST_UPDATE;
        end else begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan_run = 1'b1;
        if (stat.hit) begin
          cmd.set_verdict = 1'b1;
          cmd.code        = V_RETIRED;
          state_nxt       = ST_RESP;
        end else if (stat.scan_done) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = ST_RESP;
      end
      ST_RESP: begin
        // result fields are held in registers, so the next transfer may start here
        out_strobe = 1'b1;
        busy       = 1'b0;
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_LOOKUP;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> sv/srw_dp.sv
// Datapath for the session replay window block: input latch, per-pair window state,
// retired-session memory with serial scan, window update and result registers.
// Depends on srw_pkg; commanded by srw_ctrl.
`default_nettype none

module srw_dp
  import srw_pkg::*;
#(
  parameter int ENDPOINTS     = ENDPOINTS_DEF,
  parameter int RETIRED_DEPTH = RETIRED_DEPTH_DEF,
  parameter int WINDOW_BITS   = WINDOW_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire srw_cmd_t           cmd,
  output srw_stat_t               stat,
  input  wire logic               in_action,
  input  wire logic        [1:0]  in_receiver,
  input  wire logic        [1:0]  in_sender,
  input  wire logic        [31:0] in_session_id,
  input  wire logic signed [31:0] in_sequence_req,
  output logic                    out_accepted,
  output logic             [2:0]  out_verdict,
  output logic             [30:0] out_highest_seen,
  output logic             [31:0] out_history_mask
);

  localparam int PAIRS  = ENDPOINTS * ENDPOINTS;
  localparam int PAIR_W = $clog2(PAIRS);
  localparam int CNT_W  = $clog2(RETIRED_DEPTH + 1);
  localparam int SLOT_W = (RETIRED_DEPTH > 1) ? $clog2(RETIRED_DEPTH) : 1;
  localparam int SUM_W  = CNT_W + 1;
  localparam int MEM_D  = PAIRS * RETIRED_DEPTH;
  localparam int ADDR_W = $clog2(MEM_D);
  localparam int SH_W   = $clog2(WINDOW_BITS);
  localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(RETIRED_DEPTH);
  localparam logic [WINDOW_BITS-1:0] ONE_W = WINDOW_BITS'(1);

  // captured transfer
  logic        action_r;
  logic [1:0]  rcv_r, snd_r;
  logic [31:0] sess_r;
  logic [31:0] seq_r;

  // per-pair state
  logic [31:0]            cur_r    [PAIRS];
  logic [30:0]            high_r   [PAIRS];
  logic [WINDOW_BITS-1:0] mask_r   [PAIRS];
  logic [CNT_W-1:0]       cnt_r    [PAIRS];
  logic [SLOT_W-1:0]      oldest_r [PAIRS];

  // retired sessions, one ring of RETIRED_DEPTH per pair
  logic [31:0] ret_mem [MEM_D];
  logic [31:0] rd_data_r;

  logic [CNT_W-1:0] scan_i_r;
  logic             cmp_vld_r;
  verdict_t         verdict_r;

  logic [PAIR_W-1:0] pair;
  logic              ep_bad;
  logic [31:0]       cur;
  logic [30:0]       high;
  logic [WINDOW_BITS-1:0] mask;
  logic [CNT_W-1:0]  cnt;
  logic [SLOT_W-1:0] oldest;
  logic              new_sess;
  logic              issue;
  logic [SUM_W-1:0]  rsum, wsum;
  logic [SUM_W-1:0]  rslot, wslot;
  logic [ADDR_W-1:0] raddr, waddr;
  logic              do_retire;
  logic              ring_full;
  logic [SLOT_W-1:0] oldest_inc;

  // window update
  logic [30:0]            base_high, seq31, high_n, diff;
  logic [WINDOW_BITS-1:0] base_mask, mask_n, bit_sel;
  logic [SH_W-1:0]        sh_m1;
  logic                   in_win;
  verdict_t               win_verdict;
  logic [WINDOW_BITS+31:0] mask_ext;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action_r <= in_action;
      rcv_r    <= in_receiver;
      snd_r    <= in_sender;
      sess_r   <= in_session_id;
      seq_r    <= in_sequence_req;
    end
  end

  assign ep_bad = (32'(rcv_r) >= ENDPOINTS) || (32'(snd_r) >= ENDPOINTS);
  assign pair   = PAIR_W'(32'(rcv_r) * ENDPOINTS + 32'(snd_r));

  assign cur    = cur_r[pair];
  assign high   = high_r[pair];
  assign mask   = mask_r[pair];
  assign cnt    = cnt_r[pair];
  assign oldest = oldest_r[pair];
  assign new_sess = (sess_r != cur);

  assign stat.bad = ep_bad ||
                    (!action_r && ((sess_r == '0) || (seq_r == '0) || seq_r[31]));
  assign stat.query        = action_r;
  assign stat.same_session = !new_sess;

  // scan: one read issued per cycle, compared the cycle after
  assign issue = cmd.scan_run && (scan_i_r < cnt);
  assign rsum  = SUM_W'(oldest) + SUM_W'(scan_i_r);
  assign rslot = (rsum >= DEPTH_S) ? rsum - DEPTH_S : rsum;
  assign raddr = ADDR_W'(32'(pair) * RETIRED_DEPTH + 32'(rslot));

  assign stat.hit       = cmp_vld_r && (rd_data_r == sess_r);
  assign stat.scan_done = (scan_i_r >= cnt) && !cmp_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_i_r  <= '0;
      cmp_vld_r <= 1'b0;
    end else if (cmd.scan_clr) begin
      scan_i_r  <= '0;
      cmp_vld_r <= 1'b0;
    end else begin
      cmp_vld_r <= issue;
      if (issue) begin
        scan_i_r <= scan_i_r + 1'b1;
      end
    end
  end

  // retire write slot
  assign ring_full  = (cnt >= CNT_W'(RETIRED_DEPTH));
  assign wsum       = ring_full ? SUM_W'(oldest) : SUM_W'(oldest) + SUM_W'(cnt);
  assign wslot      = (wsum >= DEPTH_S) ? wsum - DEPTH_S : wsum;
  assign waddr      = ADDR_W'(32'(pair) * RETIRED_DEPTH + 32'(wslot));
  assign do_retire  = cmd.update && new_sess && (cur != '0);
  assign oldest_inc = (32'(oldest) + 1 >= RETIRED_DEPTH) ? '0 : oldest + 1'b1;

  always_ff @(posedge clk) begin
    if (do_retire) begin
      ret_mem[waddr] <= cur;
    end
    rd_data_r <= ret_mem[raddr];
  end

  // window: slide forward, mark an earlier slot, or reject
  assign base_high = new_sess ? '0 : high;
  assign base_mask = new_sess ? '0 : mask;
  assign seq31     = seq_r[30:0];
  assign diff      = (seq31 > base_high) ? seq31 - base_high : base_high - seq31;
  assign in_win    = (32'(diff) < WINDOW_BITS);
  assign sh_m1     = diff[SH_W-1:0] - 1'b1;
  assign bit_sel   = ONE_W << sh_m1;

  always_comb begin
    high_n      = base_high;
    mask_n      = base_mask;
    win_verdict = V_OK;
    if (seq31 > base_high) begin
      high_n = seq31;
      mask_n = in_win ? ((base_mask << diff[SH_W-1:0]) | bit_sel) : '0;
    end else if (seq31 == base_high) begin
      win_verdict = V_DUP;
    end else if (!in_win) begin
      win_verdict = V_OLD;
    end else if ((base_mask & bit_sel) != '0) begin
      win_verdict = V_DUP;
    end else begin
      mask_n = base_mask | bit_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PAIRS; i++) begin
        cur_r[i]    <= '0;
        high_r[i]   <= '0;
        mask_r[i]   <= '0;
        cnt_r[i]    <= '0;
        oldest_r[i] <= '0;
      end
    end else if (cmd.update) begin
      cur_r[pair]  <= sess_r;
      high_r[pair] <= high_n;
      mask_r[pair] <= mask_n;
      if (do_retire) begin
        if (ring_full) begin
          oldest_r[pair] <= oldest_inc;
        end else begin
          cnt_r[pair] <= cnt + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      verdict_r <= V_OK;
    end else if (cmd.set_verdict) begin
      verdict_r <= cmd.code;
    end else if (cmd.update) begin
      verdict_r <= win_verdict;
    end
  end

  // result fields follow the pair state, which holds until the next update
  assign mask_ext         = {32'b0, mask};
  assign out_accepted     = (verdict_r == V_OK);
  assign out_verdict      = verdict_r;
  assign out_highest_seen = (verdict_r == V_BAD) ? '0 : high;
  assign out_history_mask = (verdict_r == V_BAD) ? '0 : mask_ext[31:0];

endmodule

`default_nettype wire

>>> sv/session_replay_window.sv
// Top level of the session replay window block (sliding-window anti-replay check).
// Depends on srw_pkg; instantiates srw_ctrl (state machine) and srw_dp (datapath).
//
//   channel  | handshake                 | payload ports
//   ---------+---------------------------+------------------------------------------
//   input    | start in, busy out        | in_action, in_receiver, in_sender,
//            | (transfer: start & !busy) |   in_session_id, in_sequence_req
//   result   | out_strobe out, 1 cycle   | out_accepted, out_verdict,
//            | (no back-pressure)        |   out_highest_seen, out_history_mask
//
// A query or a rejected argument goes from lookup straight to the strobe state.
// A packet on the current session passes through update first; a new session scans
// the pair's retired list one memory read per cycle (up to RETIRED_DEPTH entries,
// 8 by default); a hit ends it early, else it sees the scan done, then updates.
// A new transfer is taken in the strobe cycle. Reset is synchronous, active low, and
// clears all pair state at once; the retired-session memory needs no clearing since
// only entries below the pair's retired count are ever read.
`default_nettype none

module session_replay_window
  import srw_pkg::*;
#(
  parameter int ENDPOINTS     = ENDPOINTS_DEF,
  parameter int RETIRED_DEPTH = RETIRED_DEPTH_DEF,
  parameter int WINDOW_BITS   = WINDOW_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               in_action,
  input  wire logic        [1:0]  in_receiver,
  input  wire logic        [1:0]  in_sender,
  input  wire logic        [31:0] in_session_id,
  input  wire logic signed [31:0] in_sequence_req,
  output logic                    out_strobe,
  output logic                    out_accepted,
  output logic             [2:0]  out_verdict,
  output logic             [30:0] out_highest_seen,
  output logic             [31:0] out_history_mask
);

  srw_cmd_t  cmd;
  srw_stat_t stat;

  // sequencing: lookup, optional retired scan, update (skipped for a query, bad argument or retired hit), result
  srw_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .stat       (stat),
    .cmd        (cmd),
    .busy       (busy),
    .out_strobe (out_strobe)
  );

  // pair state, retired memory and window arithmetic
  srw_dp #(
    .ENDPOINTS     (ENDPOINTS),
    .RETIRED_DEPTH (RETIRED_DEPTH),
    .WINDOW_BITS   (WINDOW_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_action        (in_action),
    .in_receiver      (in_receiver),
    .in_sender        (in_sender),
    .in_session_id    (in_session_id),
    .in_sequence_req  (in_sequence_req),
    .out_accepted     (out_accepted),
    .out_verdict      (out_verdict),
    .out_highest_seen (out_highest_seen),
    .out_history_mask (out_history_mask)
  );

endmodule

`default_nettype wire
